FILE: rtl/arp_cache_resolver_defines.svh
// Assertion macros for the resolver RTL.
`ifndef ARP_CACHE_RESOLVER_DEFINES_SVH
`define ARP_CACHE_RESOLVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ARPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/arpc_pkg.sv
`timescale 1ns / 1ps

package arpc_pkg;

	localparam int ENTRIES     = 32;
	localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int MAX_RESULTS = 32;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam int TIME_W = 48;
	localparam int MAC_W  = 48;
	localparam int IP_W   = 32;
	localparam int HDL_W  = 16;

	localparam logic [MAC_W-1:0] BCAST_MAC   = '1;
	localparam logic [IP_W-1:0]  BCAST_IP    = '1;
	localparam logic [2:0]       RETRY_LIMIT = 3'd5;

	// Item modes.
	localparam logic [1:0] MODE_TX   = 2'd0;
	localparam logic [1:0] MODE_ARP  = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	// Result actions.
	localparam logic [1:0] ACT_SEND = 2'd0;
	localparam logic [1:0] ACT_ARP  = 2'd1;
	localparam logic [1:0] ACT_FREE = 2'd2;

	// ARP opcodes as carried in results, and the received request opcode.
	localparam logic [1:0]  OP_NONE    = 2'd0;
	localparam logic [1:0]  OP_REQUEST = 2'd1;
	localparam logic [1:0]  OP_REPLY   = 2'd2;
	localparam logic [15:0] ARP_OP_REQ = 16'd1;

	// Header checks on a received ARP item.
	localparam logic [15:0] HW_ETHER   = 16'd1;
	localparam logic [15:0] PROTO_IPV4 = 16'h0800;
	localparam logic [7:0]  HW_LEN     = 8'd6;
	localparam logic [7:0]  PROTO_LEN  = 8'd4;
	localparam logic [15:0] MIN_FRAME  = 16'd28;

	// Configuration register indexes.
	localparam logic [2:0] CFG_LOCAL_IP    = 3'd0;
	localparam logic [2:0] CFG_SUBNET_MASK = 3'd1;
	localparam logic [2:0] CFG_LOCAL_MAC   = 3'd2;
	localparam logic [2:0] CFG_RETRY       = 3'd3;
	localparam logic [2:0] CFG_TTL         = 3'd4;

	typedef struct packed {
		logic [1:0]        mode;
		logic [TIME_W-1:0] now_ms;
		logic [HDL_W-1:0]  packet_handle;
		logic [IP_W-1:0]   peer_ip;
		logic [IP_W-1:0]   target_ip;
		logic [MAC_W-1:0]  sender_mac;
		logic [15:0]       arp_op;
		logic [15:0]       hw_type;
		logic [15:0]       proto_type;
		logic [7:0]        hw_len;
		logic [7:0]        proto_len;
		logic [15:0]       frame_len;
	} req_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [MAC_W-1:0] dest_mac;
		logic [HDL_W-1:0] packet_out;
		logic [1:0]       arp_op_out;
		logic [MAC_W-1:0] target_hw;
		logic [IP_W-1:0]  target_proto;
		logic             last;
	} res_t;

	typedef struct packed {
		logic [IP_W-1:0]   ip;
		logic [MAC_W-1:0]  mac;
		logic              valid;
		logic              pending;
		logic [HDL_W-1:0]  handle;
		logic [TIME_W-1:0] updated;
		logic [TIME_W-1:0] last_req;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic push;
		logic flush;
	} emit_ctl_t;

	typedef struct packed {
		logic rdy;
		logic held;
	} emit_sts_t;

	function automatic res_t make_res(logic [1:0] action, logic [MAC_W-1:0] dmac,
			logic [HDL_W-1:0] pkt, logic [1:0] op, logic [MAC_W-1:0] thw,
			logic [IP_W-1:0] tpa);
		res_t r;
		r.action       = action;
		r.dest_mac     = dmac;
		r.packet_out   = pkt;
		r.arp_op_out   = op;
		r.target_hw    = thw;
		r.target_proto = tpa;
		r.last         = 1'b0;
		return r;
	endfunction

	// Elapsed time, wrapping modulo 2^48.
	function automatic logic [TIME_W-1:0] age_ms(logic [TIME_W-1:0] now,
			logic [TIME_W-1:0] then);
		return now - then;
	endfunction

endpackage

FILE: rtl/arpc_ram.sv
`timescale 1ns / 1ps

module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/arpc_out.sv
`timescale 1ns / 1ps

module arpc_out (
	input  logic              clk,
	input  logic              arst_n,
	input  arpc_pkg::emit_ctl_t ctl,
	input  arpc_pkg::res_t    push_data,
	output arpc_pkg::emit_sts_t sts,
	output logic              res_valid,
	input  logic              res_stall,
	output arpc_pkg::res_t    res_item
);
	import arpc_pkg::*;

	// The newest result is held back one step so that the final one of an
	// item can be marked when the item ends.
	res_t held_q;
	logic held_v_q;
	logic out_free;
	logic move;
	res_t move_item;

	assign out_free = !res_valid || !res_stall;
	assign sts.rdy  = !held_v_q || out_free;
	assign sts.held = held_v_q;
	assign move     = (ctl.push || ctl.flush) && held_v_q && out_free;

	always_comb begin
		move_item      = held_q;
		move_item.last = ctl.flush;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q  <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				res_valid <= 1'b0;
			end
			if (move) begin
				res_valid <= 1'b1;
			end
			if (ctl.push && sts.rdy) begin
				held_v_q <= 1'b1;
			end else if (ctl.flush && sts.rdy) begin
				held_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			res_item <= move_item;
		end
		if (ctl.push && sts.rdy) begin
			held_q <= push_data;
		end
	end

endmodule

FILE: rtl/arp_cache_resolver.sv
`timescale 1ns / 1ps
// A transmit to a broadcast address skips the scan, and an ARP item with a bad header or an
// item of unknown mode goes straight to the flush; other items scan all ENTRIES cache slots
// through the single read port of the entry memory, one per cycle while no tick result is
// held back. A new item is taken only once the previous one has finished, and result stalls
// hold the block. Reset sets the control and configuration registers and clears the per-slot
// written flags at once; an unwritten slot reads as all zero, so there is no clearing pass
// and the block accepts items right after reset.

module arp_cache_resolver (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  arpc_pkg::req_t req_item,
	output logic           res_valid,
	input  logic           res_stall,
	output arpc_pkg::res_t res_item,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [47:0]    cfg_data
);
	import arpc_pkg::*;

	`include "arp_cache_resolver_defines.svh"

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_EMIT,
		ST_FLUSH
	} state_t;

	// Configuration registers.
	logic [IP_W-1:0]  local_ip_q;
	logic [IP_W-1:0]  subnet_mask_q;
	logic [MAC_W-1:0] local_mac_q;
	logic [15:0]      retry_q;
	logic [31:0]      ttl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q    <= '0;
			subnet_mask_q <= '0;
			local_mac_q   <= '0;
			retry_q       <= 16'd1000;
			ttl_q         <= 32'd600000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOCAL_IP:    local_ip_q    <= cfg_data[IP_W-1:0];
				CFG_SUBNET_MASK: subnet_mask_q <= cfg_data[IP_W-1:0];
				CFG_LOCAL_MAC:   local_mac_q   <= cfg_data;
				CFG_RETRY:       retry_q       <= cfg_data[15:0];
				CFG_TTL:         ttl_q         <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// The local MAC belongs to the frame builder downstream; it is kept here so
	// that the whole register set lives in one place. It feeds no result.
	logic mac_cfg_seen;
	assign mac_cfg_seen = |local_mac_q;

	// Control state.
	state_t           state_q;
	req_t             req_q;
	logic             bcast_q;
	logic [IDX_W:0]   rd_cnt_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             wr_s1;
	logic [CNT_W-1:0] cnt_q;
	logic             slot_q;
	logic [ENTRIES-1:0] written_q;

	// Search results gathered while the scan runs.
	logic             found_q;
	logic [IDX_W-1:0] midx_q;
	entry_t           mrec_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [IDX_W-1:0] min_idx_q;
	logic [TIME_W-1:0] min_upd_q;
	logic             min_pend_q;
	logic [HDL_W-1:0] min_hdl_q;

	// Up to two results of a transmit or ARP item, sent in order.
	res_t slot0_q;
	res_t slot1_q;
	logic en0_q;
	logic en1_q;

	// Entry memory.
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	arpc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Result staging.
	emit_ctl_t emit_ctl;
	emit_sts_t emit_sts;
	res_t      push_data;

	arpc_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (emit_ctl),
		.push_data (push_data),
		.sts       (emit_sts),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	// Items are taken only between items; configuration is to be written then (unenforced).
	assign req_stall = (state_q != ST_IDLE);

	logic accept;
	assign accept = req_valid && !req_stall;

	// Classification of the incoming item, done at acceptance.
	logic [IP_W-1:0] subnet_bc;
	logic            in_bcast;
	logic            in_hdr_ok;
	assign subnet_bc = (local_ip_q & subnet_mask_q) | ~subnet_mask_q;
	assign in_bcast  = (req_item.peer_ip == BCAST_IP) ||
		((subnet_mask_q != '0) && (req_item.peer_ip == subnet_bc));
	assign in_hdr_ok = (req_item.frame_len >= MIN_FRAME) && (req_item.hw_type == HW_ETHER) &&
		(req_item.proto_type == PROTO_IPV4) && (req_item.hw_len == HW_LEN) &&
		(req_item.proto_len == PROTO_LEN);

	logic cnt_room;
	assign cnt_room = (cnt_q < CNT_W'(MAX_RESULTS));

	logic is_tick;
	assign is_tick = (req_q.mode == MODE_TICK);

	// Entry read in the scan; an unwritten slot reads as all zero.
	entry_t ent;
	assign ent = wr_s1 ? entry_t'(ram_rdata) : '0;

	// Timer tick: expire, retry or abandon the entry in the scan stage.
	logic [TIME_W-1:0] t_age_upd;
	logic [TIME_W-1:0] t_age_req;
	logic [18:0]       retry_x5;
	logic              t_timeout;
	logic              t_retry;
	entry_t            t_rec;
	res_t              t_res;
	assign t_age_upd = age_ms(req_q.now_ms, ent.updated);
	assign t_age_req = age_ms(req_q.now_ms, ent.last_req);
	assign retry_x5  = {1'b0, retry_q, 2'b00} + 19'(retry_q);
	assign t_timeout = ent.pending && (t_age_req > TIME_W'(retry_x5));
	assign t_retry   = ent.pending && !t_timeout && (t_age_req >= TIME_W'(retry_q));

	always_comb begin
		t_rec = ent;
		t_rec.valid   = ent.valid && !(t_age_upd > TIME_W'(ttl_q));
		t_rec.pending = ent.pending && !t_timeout;
		if (t_retry) begin
			t_rec.last_req = req_q.now_ms;
		end
		if (t_timeout) begin
			t_res = make_res(ACT_FREE, '0, ent.handle, OP_NONE, '0, '0);
		end else begin
			t_res = make_res(ACT_ARP, BCAST_MAC, '0, OP_REQUEST, '0, ent.ip);
		end
	end

	// The scan stage holds while a tick result cannot be handed on.
	logic need_push;
	logic advance;
	logic scan_done;
	assign need_push = vld_s1 && is_tick && (t_timeout || t_retry) && cnt_room;
	assign advance   = !need_push || emit_sts.rdy;
	assign scan_done = !vld_s1 && (rd_cnt_q == (IDX_W+1)'(ENTRIES));

	// Decision for a transmit or ARP item once the scan has found its slot.
	logic              live_s1;
	logic [IDX_W-1:0]  vidx;
	logic              vfree;
	entry_t            base;
	logic [IDX_W-1:0]  eidx;
	logic              for_us;
	logic              req_due;
	logic [TIME_W-1:0] base_age;
	res_t              r_victim;
	res_t              d_r0;
	res_t              d_r1;
	logic              d_en0;
	logic              d_en1;
	logic              d_we;
	entry_t            d_rec;

	assign live_s1  = ent.valid || ent.pending;
	assign vidx     = free_found_q ? free_idx_q : min_idx_q;
	assign vfree    = !found_q && !free_found_q && min_pend_q;
	assign eidx     = found_q ? midx_q : vidx;
	assign for_us   = (local_ip_q != '0) && (req_q.target_ip == local_ip_q);
	assign r_victim = make_res(ACT_FREE, '0, min_hdl_q, OP_NONE, '0, '0);
	assign base_age = age_ms(req_q.now_ms, base.last_req);
	assign req_due  = (base_age >= TIME_W'(retry_q)) || (base.last_req == '0);

	always_comb begin
		// A claimed slot starts from scratch with the new address.
		if (found_q) begin
			base = mrec_q;
		end else begin
			base    = '0;
			base.ip = req_q.peer_ip;
		end
		d_rec = base;
		d_r0  = r_victim;
		d_r1  = make_res(ACT_SEND, BCAST_MAC, req_q.packet_handle, OP_NONE, '0, '0);
		d_en0 = 1'b0;
		d_en1 = 1'b0;
		d_we  = 1'b0;
		if (req_q.mode == MODE_TX) begin
			if (bcast_q) begin
				d_en1 = 1'b1;
			end else if (base.valid) begin
				// Resolved neighbor: the packet goes straight out.
				d_en0 = vfree;
				d_en1 = 1'b1;
				d_r1  = make_res(ACT_SEND, base.mac, req_q.packet_handle, OP_NONE, '0, '0);
			end else begin
				// Park the packet, replacing any older one, and ask if due.
				d_we          = 1'b1;
				d_en0         = vfree || base.pending;
				if (base.pending) begin
					d_r0 = make_res(ACT_FREE, '0, base.handle, OP_NONE, '0, '0);
				end
				d_rec.pending = 1'b1;
				d_rec.handle  = req_q.packet_handle;
				if (req_due) begin
					d_rec.last_req = req_q.now_ms;
				end
				d_en1 = req_due;
				d_r1  = make_res(ACT_ARP, BCAST_MAC, '0, OP_REQUEST, '0, req_q.peer_ip);
			end
		end else begin
			// Received ARP: learn when it is for us or the sender is known,
			// release a parked packet, and answer a request for our address.
			d_we          = for_us || found_q;
			d_rec.mac     = req_q.sender_mac;
			d_rec.valid   = 1'b1;
			d_rec.updated = req_q.now_ms;
			d_rec.pending = 1'b0;
			d_en0         = d_we && (vfree || base.pending);
			if (base.pending) begin
				d_r0 = make_res(ACT_SEND, req_q.sender_mac, base.handle, OP_NONE, '0, '0);
			end
			d_en1 = for_us && (req_q.arp_op == ARP_OP_REQ);
			d_r1  = make_res(ACT_ARP, req_q.sender_mac, '0, OP_REPLY, req_q.sender_mac,
				req_q.peer_ip);
		end
	end

	logic emit_en;
	assign emit_en = (slot_q ? en1_q : en0_q) && cnt_room;

	// Memory ports and result handshake.
	always_comb begin
		ram_re    = (state_q == ST_SCAN) && advance && (rd_cnt_q < (IDX_W+1)'(ENTRIES));
		ram_raddr = rd_cnt_q[IDX_W-1:0];
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = t_rec;
		emit_ctl  = '0;
		push_data = t_res;
		unique case (state_q)
			ST_SCAN: begin
				ram_we        = vld_s1 && is_tick && advance;
				emit_ctl.push = need_push;
			end
			ST_DECIDE: begin
				ram_we    = d_we;
				ram_waddr = eidx;
				ram_wdata = d_rec;
			end
			ST_EMIT: begin
				emit_ctl.push = emit_en;
				push_data     = slot_q ? slot1_q : slot0_q;
			end
			ST_FLUSH: begin
				emit_ctl.flush = 1'b1;
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_cnt_q  <= '0;
			vld_s1    <= 1'b0;
			cnt_q     <= '0;
			slot_q    <= 1'b0;
			written_q <= '0;
		end else begin
			if (ram_we) begin
				written_q[ram_waddr] <= 1'b1;
			end
			if (emit_ctl.push && emit_sts.rdy) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_cnt_q <= '0;
						vld_s1   <= 1'b0;
						cnt_q    <= '0;
						slot_q   <= 1'b0;
						if (req_item.mode == MODE_TX) begin
							state_q <= in_bcast ? ST_DECIDE : ST_SCAN;
						end else if (req_item.mode == MODE_ARP) begin
							state_q <= in_hdr_ok ? ST_SCAN : ST_FLUSH;
						end else if (req_item.mode == MODE_TICK) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= is_tick ? ST_FLUSH : ST_DECIDE;
					end else if (advance) begin
						vld_s1 <= ram_re;
						if (ram_re) begin
							rd_cnt_q <= rd_cnt_q + (IDX_W+1)'(1);
						end
					end
				end
				ST_DECIDE: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!emit_en || emit_sts.rdy) begin
						slot_q <= 1'b1;
						if (slot_q) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (emit_sts.rdy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item, scan pipeline and search registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q        <= req_item;
			bcast_q      <= in_bcast;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end
		if ((state_q == ST_SCAN) && advance && !scan_done) begin
			idx_s1 <= ram_raddr;
			wr_s1  <= written_q[ram_raddr];
		end
		if ((state_q == ST_SCAN) && vld_s1 && !is_tick) begin
			// First live entry with the address wins.
			if (live_s1 && (ent.ip == req_q.peer_ip) && !found_q) begin
				found_q <= 1'b1;
				midx_q  <= idx_s1;
				mrec_q  <= ent;
			end
			// Victim: first free slot, else the oldest update, first on ties.
			if (!live_s1 && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
			if ((idx_s1 == '0) || (ent.updated < min_upd_q)) begin
				min_idx_q  <= idx_s1;
				min_upd_q  <= ent.updated;
				min_pend_q <= ent.pending;
				min_hdl_q  <= ent.handle;
			end
		end
		if (state_q == ST_DECIDE) begin
			slot0_q <= d_r0;
			slot1_q <= d_r1;
			en0_q   <= d_en0;
			en1_q   <= d_en1 || (mac_cfg_seen && 1'b0);
		end
	end

	// The tick write-back never lands on the slot being read in the same cycle.
	`ARPC_ASSERT_IMP(a_no_rw_collision, clk, arst_n, ram_we && ram_re, ram_waddr != ram_raddr, "entry read and write collide")
	// A scan held by a blocked result keeps its read position and stage.
	`ARPC_ASSERT_NXT(a_scan_hold, clk, arst_n, (state_q == ST_SCAN) && !advance && !scan_done, $stable(rd_cnt_q) && $stable(vld_s1), "scan moved while held")
	// By the time a new item enters, the previous item's final result has left staging.
	`ARPC_ASSERT_IMP(a_drained_on_accept, clk, arst_n, accept, !emit_sts.held, "result still staged at accept")

endmodule

FILE: tb/arp_cache_resolver_checker.sv
`timescale 1ns / 1ps

module arp_cache_resolver_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  arpc_pkg::req_t req_item,
	input  logic           res_valid,
	input  logic           res_stall,
	input  arpc_pkg::res_t res_item,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [47:0]    cfg_data,
	output int             fail_count,
	output int             waiting
);
	import arpc_pkg::*;

	logic [IP_W-1:0]   my_ip, my_mask;
	logic [15:0]       retry_ms;
	logic [31:0]       ttl_ms;
	logic [IP_W-1:0]   c_ip      [ENTRIES];
	logic [MAC_W-1:0]  c_mac     [ENTRIES];
	logic              c_valid   [ENTRIES];
	logic              c_pend    [ENTRIES];
	logic [HDL_W-1:0]  c_handle  [ENTRIES];
	logic [TIME_W-1:0] c_updated [ENTRIES];
	logic [TIME_W-1:0] c_lastreq [ENTRIES];

	res_t expected_results[$];
	int   item_results;

	assign waiting = expected_results.size();

	function automatic void post_result(logic [1:0] act, logic [MAC_W-1:0] dmac,
			logic [HDL_W-1:0] pkt, logic [1:0] op, logic [MAC_W-1:0] thw,
			logic [IP_W-1:0] tpa);
		res_t r;
		if (item_results >= MAX_RESULTS)
			return;
		r.action = act;
		r.dest_mac = dmac;
		r.packet_out = pkt;
		r.arp_op_out = op;
		r.target_hw = thw;
		r.target_proto = tpa;
		r.last = 1'b0;
		expected_results.push_back(r);
		item_results++;
	endfunction

	function automatic int find_slot(logic [IP_W-1:0] ip);
		for (int i = 0; i < ENTRIES; i++)
			if (c_ip[i] == ip && (c_valid[i] || c_pend[i]))
				return i;
		return -1;
	endfunction

	// Reuse a matching slot, else the first free one, else the stalest one.
	function automatic int take_slot(logic [IP_W-1:0] ip);
		int v;
		v = find_slot(ip);
		if (v >= 0)
			return v;
		v = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!c_valid[i] && !c_pend[i]) begin
				v = i;
				break;
			end
			if (c_updated[i] < c_updated[v])
				v = i;
		end
		if (c_pend[v])
			post_result(ACT_FREE, '0, c_handle[v], OP_NONE, '0, '0);
		c_mac[v] = '0;
		c_valid[v] = 1'b0;
		c_pend[v] = 1'b0;
		c_handle[v] = '0;
		c_updated[v] = '0;
		c_lastreq[v] = '0;
		c_ip[v] = ip;
		return v;
	endfunction

	function automatic void resolve_item(req_t r);
		logic [IP_W-1:0]   bc;
		logic [TIME_W-1:0] giveup;
		logic              ok, for_us;
		int                e;
		item_results = 0;
		giveup = 48'(retry_ms) * 5;
		case (r.mode)
			MODE_TX: begin
				bc = (my_ip & my_mask) | ~my_mask;
				if (r.peer_ip == BCAST_IP || (my_mask != 0 && r.peer_ip == bc)) begin
					post_result(ACT_SEND, BCAST_MAC, r.packet_handle, OP_NONE, '0, '0);
				end else begin
					e = take_slot(r.peer_ip);
					if (c_valid[e]) begin
						post_result(ACT_SEND, c_mac[e], r.packet_handle, OP_NONE, '0, '0);
					end else begin
						if (c_pend[e])
							post_result(ACT_FREE, '0, c_handle[e], OP_NONE, '0, '0);
						c_pend[e] = 1'b1;
						c_handle[e] = r.packet_handle;
						if (age_ms(r.now_ms, c_lastreq[e]) >= 48'(retry_ms) ||
								c_lastreq[e] == 0) begin
							c_lastreq[e] = r.now_ms;
							post_result(ACT_ARP, BCAST_MAC, '0, OP_REQUEST, '0, r.peer_ip);
						end
					end
				end
			end
			MODE_ARP: begin
				ok = r.frame_len >= MIN_FRAME && r.hw_type == HW_ETHER &&
					r.proto_type == PROTO_IPV4 && r.hw_len == HW_LEN &&
					r.proto_len == PROTO_LEN;
				if (ok) begin
					for_us = my_ip != 0 && r.target_ip == my_ip;
					if (for_us || find_slot(r.peer_ip) >= 0) begin
						e = take_slot(r.peer_ip);
						c_mac[e] = r.sender_mac;
						c_valid[e] = 1'b1;
						c_updated[e] = r.now_ms;
						if (c_pend[e]) begin
							c_pend[e] = 1'b0;
							post_result(ACT_SEND, r.sender_mac, c_handle[e], OP_NONE, '0, '0);
						end
					end
					if (for_us && r.arp_op == ARP_OP_REQ)
						post_result(ACT_ARP, r.sender_mac, '0, OP_REPLY, r.sender_mac,
							r.peer_ip);
				end
			end
			MODE_TICK: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (c_valid[i] && age_ms(r.now_ms, c_updated[i]) > 48'(ttl_ms))
						c_valid[i] = 1'b0;
					if (c_pend[i] && age_ms(r.now_ms, c_lastreq[i]) > giveup) begin
						post_result(ACT_FREE, '0, c_handle[i], OP_NONE, '0, '0);
						c_pend[i] = 1'b0;
					end else if (c_pend[i] &&
							age_ms(r.now_ms, c_lastreq[i]) >= 48'(retry_ms)) begin
						c_lastreq[i] = r.now_ms;
						post_result(ACT_ARP, BCAST_MAC, '0, OP_REQUEST, '0, c_ip[i]);
					end
				end
			end
			default: ;
		endcase
		if (item_results > 0)
			expected_results[expected_results.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count <= 0;
			my_ip = '0;
			my_mask = '0;
			retry_ms = 16'd1000;
			ttl_ms = 32'd600000;
			for (int i = 0; i < ENTRIES; i++) begin
				c_ip[i] = '0;
				c_mac[i] = '0;
				c_valid[i] = 1'b0;
				c_pend[i] = 1'b0;
				c_handle[i] = '0;
				c_updated[i] = '0;
				c_lastreq[i] = '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LOCAL_IP:    my_ip = cfg_data[31:0];
					CFG_SUBNET_MASK: my_mask = cfg_data[31:0];
					CFG_RETRY:       retry_ms = cfg_data[15:0];
					CFG_TTL:         ttl_ms = cfg_data[31:0];
					default: ;
				endcase
			end
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result item: %p", res_item);
					fail_count <= fail_count + 1;
				end else begin
					res_t x;
					x = expected_results.pop_front();
					if (res_item !== x) begin
						if (res_item.action !== x.action)
							$error("action: expected %0d, got %0d", x.action, res_item.action);
						if (res_item.dest_mac !== x.dest_mac)
							$error("dest_mac: expected %h, got %h", x.dest_mac,
								res_item.dest_mac);
						if (res_item.packet_out !== x.packet_out)
							$error("packet_out: expected %h, got %h", x.packet_out,
								res_item.packet_out);
						if (res_item.arp_op_out !== x.arp_op_out)
							$error("arp_op_out: expected %0d, got %0d", x.arp_op_out,
								res_item.arp_op_out);
						if (res_item.target_hw !== x.target_hw)
							$error("target_hw: expected %h, got %h", x.target_hw,
								res_item.target_hw);
						if (res_item.target_proto !== x.target_proto)
							$error("target_proto: expected %h, got %h", x.target_proto,
								res_item.target_proto);
						if (res_item.last !== x.last)
							$error("last: expected %0d, got %0d", x.last, res_item.last);
						fail_count <= fail_count + 1;
					end
				end
			end
			// Results of this item cannot leave before the next edge.
			if (req_valid && !req_stall)
				resolve_item(req_item);
		end
	end

endmodule

FILE: tb/arp_cache_resolver_tb.sv
`timescale 1ns / 1ps

module arp_cache_resolver_tb;
	import arpc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req_item;
	logic        res_valid;
	logic        res_stall;
	res_t        res_item;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_data;
	int          fail_count;
	int          waiting;

	// When steady is set, neither side inserts bubbles.
	logic              steady;
	logic [TIME_W-1:0] clock_ms;
	logic [IP_W-1:0]   my_ip;

	localparam logic [IP_W-1:0] NET = 32'h0A00_0000;
	localparam int REQ_W = $bits(req_t);

	arp_cache_resolver dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
		.res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	arp_cache_resolver_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
		.res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .waiting(waiting)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// The result side stalls on its own, independent of the sender.
	always @(posedge clk)
		res_stall <= !steady && ($urandom_range(0, 99) < 27);

	// Present one item, with an optional bubble first, and hold it until taken.
	task automatic offer_item(input req_t it);
		if (!steady && $urandom_range(0, 99) < 27) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_item <= it;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Registers change only with the block idle. An item with no result may still
	// be scanning the cache, so a full scan time passes after the last result.
	// An edge passes first so that the results of the last item are counted.
	task automatic drain;
		req_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (ENTRIES + 20) @(posedge clk);
	endtask

	task automatic set_reg(input logic [2:0] idx, input logic [47:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic configure(input logic [31:0] ip, input logic [31:0] mask,
			input logic [47:0] mac, input logic [15:0] retry, input logic [31:0] ttl);
		drain();
		set_reg(CFG_LOCAL_IP, 48'(ip));
		set_reg(CFG_SUBNET_MASK, 48'(mask));
		set_reg(CFG_LOCAL_MAC, mac);
		set_reg(CFG_RETRY, 48'(retry));
		set_reg(CFG_TTL, 48'(ttl));
		cfg_we <= 1'b0;
		my_ip = ip;
	endtask

	function automatic req_t base_item(input logic [1:0] mode);
		req_t r;
		r = '0;
		r.mode = mode;
		r.now_ms = clock_ms;
		r.hw_type = HW_ETHER;
		r.proto_type = PROTO_IPV4;
		r.hw_len = HW_LEN;
		r.proto_len = PROTO_LEN;
		r.frame_len = MIN_FRAME;
		return r;
	endfunction

	function automatic req_t tx_item(input logic [31:0] ip, input logic [15:0] h);
		req_t r;
		r = base_item(MODE_TX);
		r.peer_ip = ip;
		r.packet_handle = h;
		return r;
	endfunction

	function automatic req_t arp_item(input logic [15:0] op, input logic [31:0] sip,
			input logic [31:0] tip, input logic [47:0] mac);
		req_t r;
		r = base_item(MODE_ARP);
		r.arp_op = op;
		r.peer_ip = sip;
		r.target_ip = tip;
		r.sender_mac = mac;
		return r;
	endfunction

	// A mix of well-formed traffic over a small neighbor set, so that entries are
	// hit, resolved, retried and evicted, plus some fully random noise.
	function automatic req_t random_item;
		req_t    r;
		int      roll;
		logic [31:0] nb;
		roll = $urandom_range(0, 99);
		nb = NET | $urandom_range(2, 41);
		if (roll < 40) begin
			r = tx_item($urandom_range(0, 19) == 0 ? BCAST_IP : nb, 16'($urandom));
		end else if (roll < 70) begin
			r = arp_item($urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(1, 2)),
				nb, $urandom_range(0, 2) != 0 ? my_ip : nb,
				{16'($urandom), 32'($urandom)});
			r.frame_len = 16'($urandom_range(28, 1500));
		end else if (roll < 85) begin
			r = base_item(MODE_TICK);
		end else begin
			r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom});
			r.now_ms = clock_ms;
		end
		return r;
	endfunction

	task automatic advance_clock;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			clock_ms = {16'($urandom), 32'($urandom)};
		else if (roll < 5)
			clock_ms = clock_ms - $urandom_range(1, 5000);
		else
			clock_ms = clock_ms + $urandom_range(0, 2500);
	endtask

	initial begin
		req_t bad;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_item <= '0;
		res_stall <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_LOCAL_IP;
		cfg_data <= '0;
		steady = 1'b0;
		clock_ms = 48'd5000;
		my_ip = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With reset values nothing is ever addressed to us.
		offer_item(tx_item(NET | 5, 16'h0001));
		offer_item(arp_item(ARP_OP_REQ, NET | 6, 32'h0, 48'h1));
		clock_ms += 2000;
		offer_item(base_item(MODE_TICK));

		configure(NET | 1, 32'hFFFF_FF00, 48'h02_00_00_00_00_01, 16'd1000, 32'd600000);
		offer_item(tx_item(BCAST_IP, 16'hFFFF));
		offer_item(tx_item(NET | 255, 16'h0000));
		// Unresolved neighbor: request goes out, then a second packet displaces the
		// first one without a new request inside the retry interval.
		offer_item(tx_item(NET | 7, 16'h1111));
		clock_ms += 10;
		offer_item(tx_item(NET | 7, 16'h2222));
		offer_item(arp_item(16'd2, NET | 7, NET | 1, 48'hAABB_CCDD_EEFF));
		offer_item(tx_item(NET | 7, 16'h3333));
		// A request for our address is learned and answered.
		offer_item(arp_item(ARP_OP_REQ, NET | 9, NET | 1, 48'h1234_5678_9ABC));
		// Neither for us nor cached: ignored.
		offer_item(arp_item(ARP_OP_REQ, NET | 50, NET | 60, 48'h1));
		// Each header check on its own, with a known sender so that a pass would show.
		bad = arp_item(16'd2, NET | 7, NET | 1, 48'h0); bad.hw_type = 16'd6;
		offer_item(bad);
		bad = arp_item(16'd2, NET | 7, NET | 1, 48'h0); bad.proto_type = 16'h86DD;
		offer_item(bad);
		bad = arp_item(16'd2, NET | 7, NET | 1, 48'h0); bad.hw_len = 8'd8;
		offer_item(bad);
		bad = arp_item(16'd2, NET | 7, NET | 1, 48'h0); bad.proto_len = 8'd16;
		offer_item(bad);
		bad = arp_item(16'd2, NET | 7, NET | 1, 48'h0); bad.frame_len = MIN_FRAME - 1;
		offer_item(bad);
		bad = base_item(2'd3);
		offer_item(bad);
		// Retry on a tick, then give up after five intervals.
		offer_item(tx_item(NET | 20, 16'h4444));
		clock_ms += 1000;
		offer_item(base_item(MODE_TICK));
		clock_ms += 5001;
		offer_item(base_item(MODE_TICK));
		// Resolved entries age out.
		clock_ms += 600001;
		offer_item(base_item(MODE_TICK));
		// A clock that steps back reads as a huge age.
		offer_item(tx_item(NET | 21, 16'h5555));
		clock_ms -= 1;
		offer_item(base_item(MODE_TICK));

		// Random part, in phases with different register settings.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: configure(NET | 1, 32'hFFFF_FF00, 48'hFFFF_FFFF_FFFF, 16'd500, 32'd20000);
				1: configure(NET | 1, 32'h0, 48'h0, 16'd1, 32'd1);
				2: configure(32'h0, 32'hFFFF_FFFF, 48'h5A5A_A5A5_0F0F, 16'd65535,
					32'hFFFF_FFFF);
				3: configure(NET | 1, 32'hFFFF_0000, {16'($urandom), 32'($urandom)}, 16'd0,
					32'd0);
				default: configure(32'hFFFF_FFFF, 32'hFFFF_FFF0, 48'h1, 16'd3000,
					32'd100000);
			endcase
			for (int n = 0; n < 28; n++) begin
				steady = (ph == 2 && n >= 4 && n < 24);
				if (ph == 1 && n == 14)
					drain();
				advance_clock();
				offer_item(random_item());
			end
			steady = 1'b0;
		end

		req_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (ENTRIES + 20) @(posedge clk);
		if (fail_count == 0 && waiting == 0) begin
			$display("arp_cache_resolver_tb passed");
		end else begin
			$display("arp_cache_resolver_tb failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("arp_cache_resolver_tb failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/arpc_pkg.sv
rtl/arpc_ram.sv
rtl/arpc_out.sv
rtl/arp_cache_resolver.sv
tb/arp_cache_resolver_checker.sv
tb/arp_cache_resolver_tb.sv
